### sv/crt_pkg.sv
// Shared types and constants for the congruence sieve solver.
// Used by crt_rem_serial and crt_sieve_solver_unit; depends on nothing.
`timescale 1ns / 1ps

package crt_pkg;

  // The offset field has a fixed width.
  localparam int unsigned OFF_WIDTH = 16;

  // Status codes reported with every result.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOSOL = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_REM,
    S_LOAD,
    S_SEARCH,
    S_MUL,
    S_DONE
  } crt_state_e;

  // Control of the bit-serial remainder cells.
  typedef struct packed {
    logic clr;
    logic shift;
  } rem_ctl_t;

endpackage

### sv/crt_rem_serial.sv
// Bit-serial restoring remainder cell: one dividend bit per cycle while shift is set, MSB first.
// Depends on crt_pkg for the control struct.
`timescale 1ns / 1ps

module crt_rem_serial #(
  parameter int unsigned MOD_WIDTH = 16
) (
  input  logic                  clk_i,
  input  crt_pkg::rem_ctl_t     ctl_i,
  input  logic                  bit_i,
  input  logic [MOD_WIDTH-1:0]  modulus_i,
  output logic [MOD_WIDTH-1:0]  rem_o
);

  logic [MOD_WIDTH-1:0] rem_q;
  logic [MOD_WIDTH-1:0] rem_d;
  logic [MOD_WIDTH:0]   trial;
  logic [MOD_WIDTH:0]   mod_ext;

  // Shift the next bit in and subtract the modulus once if it fits.
  assign trial   = {rem_q, bit_i};
  assign mod_ext = {1'b0, modulus_i};

  always_comb begin
    if (trial >= mod_ext) begin
      rem_d = MOD_WIDTH'(trial - mod_ext);
    end else begin
      rem_d = trial[MOD_WIDTH-1:0];
    end
  end

  // The partial remainder is cleared before each pass.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      rem_q <= '0;
    end else if (ctl_i.shift) begin
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q;

endmodule

### sv/crt_sieve_solver_unit.sv
// Flow: a start item, a zero modulus or a held error goes from idle straight to
// the done state; a sieve step runs the remainder pass, the load state, the try
// loop over at most 2^MOD_WIDTH - 1 candidates and, on a match, the product
// pass; a search that fails skips the product pass and goes to the done state.
// Throughput: one item at a time; the next item is taken once the result is loaded.
// The try loop (one add and one residue update per cycle) bounds the rate.
// Reset: solution 0, step 1, status ok, no result pending.
`timescale 1ns / 1ps

module crt_sieve_solver_unit #(
  parameter int unsigned NUM_WIDTH = 63,
  parameter int unsigned MOD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [MOD_WIDTH-1:0]          modulus_i,
  input  logic [crt_pkg::OFF_WIDTH-1:0] offset_i,
  input  logic                          start_system_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [NUM_WIDTH-1:0]          solution_o,
  output logic [NUM_WIDTH-1:0]          combined_step_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned ACC_W   = NUM_WIDTH + MOD_WIDTH;
  localparam int unsigned CNT_MAX = (NUM_WIDTH > MOD_WIDTH) ? NUM_WIDTH : MOD_WIDTH;
  localparam int unsigned BC_W    = $clog2(CNT_MAX);

  crt_pkg::crt_state_e state_q, state_d;

  // Architectural state.
  logic [NUM_WIDTH-1:0] cur_sol_q;
  logic [NUM_WIDTH-1:0] cur_step_q;
  logic [1:0]           err_q;
  logic                 out_valid_q;

  // Working registers.
  logic [MOD_WIDTH-1:0] mod_q;
  logic [NUM_WIDTH-1:0] sol_q;
  logic [NUM_WIDTH-1:0] step_sh_q;
  logic [NUM_WIDTH-1:0] off_sh_q;
  logic [BC_W-1:0]      bit_cnt_q;
  logic [MOD_WIDTH-1:0] r_q;
  logic [MOD_WIDTH-1:0] s_q;
  logic [MOD_WIDTH-1:0] tgt_q;
  logic [MOD_WIDTH-1:0] try_cnt_q;
  logic [ACC_W-1:0]     acc_q;
  logic [ACC_W-1:0]     acc_d;

  // Output beat registers.
  logic [NUM_WIDTH-1:0] sol_out_q;
  logic [NUM_WIDTH-1:0] step_out_q;
  logic [1:0]           stat_out_q;

  crt_pkg::rem_ctl_t    rem_ctl;
  logic [MOD_WIDTH-1:0] sol_rem;
  logic [MOD_WIDTH-1:0] step_rem;
  logic [MOD_WIDTH-1:0] off_rem;
  logic [MOD_WIDTH-1:0] target;
  logic [NUM_WIDTH:0]   sum;
  logic                 carry;
  logic [MOD_WIDTH:0]   r_sum;
  logic [MOD_WIDTH-1:0] r_next;
  logic                 hit;
  logic                 try_last;
  logic                 rem_last;
  logic                 mul_last;
  logic                 acc_ovf;
  logic                 in_fire;
  logic                 commit_out;
  logic                 direct;

  // Remainders of solution, step and offset, taken in one pass.
  crt_rem_serial #(.MOD_WIDTH(MOD_WIDTH)) u_rem_sol (
    .clk_i     (clk_i),
    .ctl_i     (rem_ctl),
    .bit_i     (sol_q[NUM_WIDTH-1]),
    .modulus_i (mod_q),
    .rem_o     (sol_rem)
  );

  crt_rem_serial #(.MOD_WIDTH(MOD_WIDTH)) u_rem_step (
    .clk_i     (clk_i),
    .ctl_i     (rem_ctl),
    .bit_i     (step_sh_q[NUM_WIDTH-1]),
    .modulus_i (mod_q),
    .rem_o     (step_rem)
  );

  crt_rem_serial #(.MOD_WIDTH(MOD_WIDTH)) u_rem_off (
    .clk_i     (clk_i),
    .ctl_i     (rem_ctl),
    .bit_i     (off_sh_q[NUM_WIDTH-1]),
    .modulus_i (mod_q),
    .rem_o     (off_rem)
  );

  // Target residue; a zero remainder of the offset maps to zero.
  assign target = (off_rem == '0) ? '0 : MOD_WIDTH'(mod_q - off_rem);

  // One sieve try: next candidate and its residue.
  assign sum    = {1'b0, sol_q} + {1'b0, cur_step_q};
  assign carry  = sum[NUM_WIDTH];
  assign r_sum  = {1'b0, r_q} + {1'b0, s_q};
  assign r_next = (r_sum >= {1'b0, mod_q}) ? MOD_WIDTH'(r_sum - {1'b0, mod_q})
                                           : r_sum[MOD_WIDTH-1:0];
  assign hit      = (r_q == tgt_q);
  assign try_last = (try_cnt_q == MOD_WIDTH'(mod_q - MOD_WIDTH'(1)));

  // Step product, modulus bits taken MSB first.
  assign acc_d   = {acc_q[ACC_W-2:0], 1'b0}
                 + (mod_q[MOD_WIDTH-1] ? ACC_W'(cur_step_q) : '0);
  assign acc_ovf = (acc_d[ACC_W-1:NUM_WIDTH] != '0);

  assign rem_last = (bit_cnt_q == BC_W'(NUM_WIDTH - 1));
  assign mul_last = (bit_cnt_q == BC_W'(MOD_WIDTH - 1));

  // Items that need no sieve pass.
  assign direct = start_system_i || (err_q != crt_pkg::ST_OK) || (modulus_i == '0);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = direct ? crt_pkg::S_DONE : crt_pkg::S_REM;
        end
      end
      crt_pkg::S_REM: begin
        if (rem_last) begin
          state_d = crt_pkg::S_LOAD;
        end
      end
      crt_pkg::S_LOAD: begin
        state_d = crt_pkg::S_SEARCH;
      end
      crt_pkg::S_SEARCH: begin
        if (hit) begin
          state_d = crt_pkg::S_MUL;
        end else if (try_last || carry) begin
          state_d = crt_pkg::S_DONE;
        end
      end
      crt_pkg::S_MUL: begin
        if (mul_last) begin
          state_d = crt_pkg::S_DONE;
        end
      end
      crt_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = crt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = crt_pkg::S_IDLE;
      end
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready_o    = (state_q == crt_pkg::S_IDLE);
    in_fire       = in_ready_o && in_valid_i;
    rem_ctl.clr   = (state_q == crt_pkg::S_IDLE);
    rem_ctl.shift = (state_q == crt_pkg::S_REM);
    commit_out    = (state_q == crt_pkg::S_DONE) && (!out_valid_q || out_ready_i);
  end

  // Controller state, architectural state and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crt_pkg::S_IDLE;
      cur_sol_q   <= '0;
      cur_step_q  <= NUM_WIDTH'(1);
      err_q       <= crt_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (commit_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        crt_pkg::S_IDLE: begin
          if (in_fire) begin
            if (start_system_i) begin
              if (modulus_i == '0) begin
                cur_sol_q  <= '0;
                cur_step_q <= NUM_WIDTH'(1);
                err_q      <= crt_pkg::ST_NOSOL;
              end else begin
                cur_sol_q  <= NUM_WIDTH'(modulus_i);
                cur_step_q <= NUM_WIDTH'(modulus_i);
                err_q      <= crt_pkg::ST_OK;
              end
            end else if ((err_q == crt_pkg::ST_OK) && (modulus_i == '0)) begin
              err_q <= crt_pkg::ST_NOSOL;
            end
          end
        end
        crt_pkg::S_SEARCH: begin
          if (!hit) begin
            if (try_last) begin
              err_q <= crt_pkg::ST_NOSOL;
            end else if (carry) begin
              err_q <= crt_pkg::ST_OVF;
            end
          end
        end
        crt_pkg::S_MUL: begin
          if (mul_last) begin
            if (acc_ovf) begin
              err_q <= crt_pkg::ST_OVF;
            end else begin
              cur_sol_q  <= sol_q;
              cur_step_q <= acc_d[NUM_WIDTH-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath: shift registers, sieve registers, product accumulator, output beat.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      crt_pkg::S_IDLE: begin
        mod_q     <= modulus_i;
        sol_q     <= cur_sol_q;
        step_sh_q <= cur_step_q;
        off_sh_q  <= NUM_WIDTH'(offset_i);
        bit_cnt_q <= '0;
      end
      crt_pkg::S_REM: begin
        sol_q     <= {sol_q[NUM_WIDTH-2:0], 1'b0};
        step_sh_q <= {step_sh_q[NUM_WIDTH-2:0], 1'b0};
        off_sh_q  <= {off_sh_q[NUM_WIDTH-2:0], 1'b0};
        bit_cnt_q <= BC_W'(bit_cnt_q + BC_W'(1));
      end
      crt_pkg::S_LOAD: begin
        sol_q     <= cur_sol_q;
        r_q       <= sol_rem;
        s_q       <= step_rem;
        tgt_q     <= target;
        try_cnt_q <= '0;
      end
      crt_pkg::S_SEARCH: begin
        if (hit) begin
          acc_q     <= '0;
          bit_cnt_q <= '0;
        end else begin
          sol_q     <= sum[NUM_WIDTH-1:0];
          r_q       <= r_next;
          try_cnt_q <= MOD_WIDTH'(try_cnt_q + MOD_WIDTH'(1));
        end
      end
      crt_pkg::S_MUL: begin
        acc_q     <= acc_d;
        mod_q     <= {mod_q[MOD_WIDTH-2:0], 1'b0};
        bit_cnt_q <= BC_W'(bit_cnt_q + BC_W'(1));
      end
      crt_pkg::S_DONE: begin
        if (commit_out) begin
          sol_out_q  <= cur_sol_q;
          step_out_q <= cur_step_q;
          stat_out_q <= err_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign solution_o      = sol_out_q;
  assign combined_step_o = step_out_q;
  assign status_o        = stat_out_q;

`ifndef SYNTH
  // An accepted item always leaves the idle state on the next cycle.
  a_fire_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != crt_pkg::S_IDLE)
    else $error("accepted item did not start work");

  // The try counter never passes the modulus during the search.
  a_try_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crt_pkg::S_SEARCH |-> try_cnt_q < mod_q)
    else $error("sieve try count exceeds modulus");

  // Residues stay reduced below the modulus.
  a_residue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crt_pkg::S_SEARCH |-> (r_q < mod_q) && (s_q < mod_q) && (tgt_q < mod_q))
    else $error("residue not reduced");

  // The combined step is never zero.
  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_step_q != '0)
    else $error("combined step is zero");

  // A result beat is loaded only when the output register is free or drained.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == crt_pkg::S_DONE && out_valid_q && !out_ready_i |=> state_q == crt_pkg::S_DONE)
    else $error("result overwritten while pending");
`endif

endmodule
